[hdl/mpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_pkg - shared types and constants for the Mandelbrot pixel classifier
// Q4.28 limits, inside-box bounds, escape radius, register map and reset values.
// ----------------------------------------------------------------------------
package mpc_pkg;

	localparam int FRAC_BITS = 28;
	localparam int Q_W       = 32;
	localparam int PROD_W    = 2 * Q_W;
	localparam int ROW_W     = 9;
	localparam int COL_W     = 9;
	localparam int STEP_W    = 29;
	localparam int ITER_W    = 8;
	localparam int CFG_IDX_W = 2;

	typedef logic signed [Q_W-1:0]    q_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	localparam prod_t Q_MAX = prod_t'(64'sh0000_0000_7FFF_FFFF);
	localparam prod_t Q_MIN = -prod_t'(64'sh0000_0000_8000_0000);

	// inside box: -0.5 < re < 0.25, -0.5 < im < 0.5
	localparam q_t BOX_RE_LO = -q_t'(32'sd134217728);
	localparam q_t BOX_RE_HI = q_t'(32'sd67108864);
	localparam q_t BOX_IM_LO = -q_t'(32'sd134217728);
	localparam q_t BOX_IM_HI = q_t'(32'sd134217728);

	// |z|^2 >= 4 in Q8.56
	localparam logic [PROD_W-1:0] ESCAPE_SQ = 64'd1 << 58;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_RE = 2'd0,
		REG_ORIGIN_IM = 2'd1,
		REG_STEP      = 2'd2,
		REG_MAX_ITER  = 2'd3
	} reg_idx_t;

	localparam q_t                RST_ORIGIN_RE = -q_t'(32'sd536870912);
	localparam q_t                RST_ORIGIN_IM = q_t'(32'sd536870912);
	localparam logic [STEP_W-1:0] RST_STEP      = 29'd2097152;
	localparam logic [ITER_W-1:0] RST_MAX_ITER  = 8'd200;

	// clamp a wide signed value to the Q4.28 range
	function automatic q_t sat_q(input prod_t v);
		q_t r;
		if (v > Q_MAX)
			r = q_t'(Q_MAX[Q_W-1:0]);
		else if (v < Q_MIN)
			r = q_t'(Q_MIN[Q_W-1:0]);
		else
			r = q_t'(v[Q_W-1:0]);
		return r;
	endfunction

endpackage : mpc_pkg
`default_nettype wire

[hdl/mandelbrot_pixel_classifier_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_pixel_classifier_core - escape-time classifier for one pixel
// Maps (row, col) to c, tests the inside box, then iterates z = z*z + c on
// one shared 32x32 multiplier until |z|^2 >= 4 or the iteration limit.
// ----------------------------------------------------------------------------
// Sequence: col*step and row*step through the multiplier, then c from the
//   products and the inside-box test; a point in the box (or a zero limit)
//   ends there with the done strobe, otherwise the escape loop follows.
// Throughput: one pixel at a time; every iteration forms x*x, y*y and x*y
//   through the single multiplier, then the update unless the loop ends there.
// The result is a one-cycle done strobe; the receiver cannot stall. busy drops
//   with the strobe, so the next start beat may land in that same cycle.
// Reset (arst_n low, async): sequencer idle, no strobe, configuration registers at defaults.

module mandelbrot_pixel_classifier_core (
	input  wire                              clk,
	input  wire                              arst_n,
	// pixel command
	input  wire                              start,
	output logic                             busy,
	input  wire  [mpc_pkg::ROW_W-1:0]        pixel_row,
	input  wire  [mpc_pkg::COL_W-1:0]        pixel_col,
	// result beat
	output logic                             done,
	output logic [mpc_pkg::ITER_W-1:0]       escape_count,
	output logic                             inside_set,
	// configuration write channel
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [mpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [mpc_pkg::Q_W-1:0]          cfg_data
);

	// one-hot sequencer
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,  // wait for start
		ST_MAPR = 9'b000000010,  // mul: col * step
		ST_MAPI = 9'b000000100,  // c_re from product, mul: row * step
		ST_CIM  = 9'b000001000,  // c_im from product
		ST_BOX  = 9'b000010000,  // inside-box shortcut, seed z = c
		ST_SQX  = 9'b000100000,  // mul: x * x
		ST_SQY  = 9'b001000000,  // mul: y * y
		ST_XY   = 9'b010000000,  // escape test, mul: x * y
		ST_UPD  = 9'b100000000   // z = z*z + c
	} state_t;

	state_t state_q;

	// configuration registers
	mpc_pkg::q_t                 origin_re_q;
	mpc_pkg::q_t                 origin_im_q;
	logic [mpc_pkg::STEP_W-1:0]  step_q;
	logic [mpc_pkg::ITER_W-1:0]  max_iter_q;

	// working registers (payload, no reset)
	logic [mpc_pkg::ROW_W-1:0]   row_q;
	logic [mpc_pkg::COL_W-1:0]   col_q;
	mpc_pkg::q_t                 c_re_q;
	mpc_pkg::q_t                 c_im_q;
	mpc_pkg::q_t                 x_q;
	mpc_pkg::q_t                 y_q;
	mpc_pkg::prod_t              mul_q;   // registered multiplier output
	mpc_pkg::prod_t              xx_q;    // x*x held while y*y is formed
	mpc_pkg::prod_t              diff_q;  // x*x - y*y
	logic [mpc_pkg::ITER_W-1:0]  iter_q;

	// shared multiplier
	mpc_pkg::q_t                 mul_a;
	mpc_pkg::q_t                 mul_b;
	mpc_pkg::prod_t              mul_p;

	// derived values
	mpc_pkg::q_t                 c_re_nxt;
	mpc_pkg::q_t                 c_im_nxt;
	mpc_pkg::q_t                 x_nxt;
	mpc_pkg::q_t                 y_nxt;
	logic [mpc_pkg::PROD_W-1:0]  mag_sq;
	logic                        escaped;
	logic                        in_box;
	logic                        accept;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// operand select for the one multiplier
	// ------------------------------------------------------------------
	always_comb begin
		case (state_q)
			ST_MAPR: begin
				mul_a = mpc_pkg::q_t'({{(mpc_pkg::Q_W-mpc_pkg::COL_W){1'b0}}, col_q});
				mul_b = mpc_pkg::q_t'({{(mpc_pkg::Q_W-mpc_pkg::STEP_W){1'b0}}, step_q});
			end
			ST_MAPI: begin
				mul_a = mpc_pkg::q_t'({{(mpc_pkg::Q_W-mpc_pkg::ROW_W){1'b0}}, row_q});
				mul_b = mpc_pkg::q_t'({{(mpc_pkg::Q_W-mpc_pkg::STEP_W){1'b0}}, step_q});
			end
			ST_SQX: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			ST_SQY: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			ST_XY: begin
				mul_a = x_q;
				mul_b = y_q;
			end
			default: begin
				mul_a = x_q;
				mul_b = y_q;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ------------------------------------------------------------------
	// point mapping, box test, escape test and z update
	// ------------------------------------------------------------------
	// c_re = origin_re + col*step, c_im = origin_im - row*step, both clamped
	assign c_re_nxt = mpc_pkg::sat_q({{mpc_pkg::Q_W{origin_re_q[mpc_pkg::Q_W-1]}},
		origin_re_q} + mul_q);
	assign c_im_nxt = mpc_pkg::sat_q({{mpc_pkg::Q_W{origin_im_q[mpc_pkg::Q_W-1]}},
		origin_im_q} - mul_q);

	assign in_box = (c_re_q > mpc_pkg::BOX_RE_LO) && (c_re_q < mpc_pkg::BOX_RE_HI) &&
		(c_im_q > mpc_pkg::BOX_IM_LO) && (c_im_q < mpc_pkg::BOX_IM_HI);

	// both squares are non-negative and at most 2^62, so the sum cannot wrap
	assign mag_sq  = xx_q + mul_q;
	assign escaped = (mag_sq >= mpc_pkg::ESCAPE_SQ);

	// arithmetic shift is a floor division; 2*x*y / 2^28 is x*y >>> 27
	// (all operands signed so the shift keeps the sign)
	assign x_nxt = mpc_pkg::sat_q((diff_q >>> mpc_pkg::FRAC_BITS) +
		mpc_pkg::prod_t'(c_re_q));
	assign y_nxt = mpc_pkg::sat_q((mul_q >>> (mpc_pkg::FRAC_BITS - 1)) +
		mpc_pkg::prod_t'(c_im_q));

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_re_q <= mpc_pkg::RST_ORIGIN_RE;
			origin_im_q <= mpc_pkg::RST_ORIGIN_IM;
			step_q      <= mpc_pkg::RST_STEP;
			max_iter_q  <= mpc_pkg::RST_MAX_ITER;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mpc_pkg::REG_ORIGIN_RE: origin_re_q <= mpc_pkg::q_t'(cfg_data);
				mpc_pkg::REG_ORIGIN_IM: origin_im_q <= mpc_pkg::q_t'(cfg_data);
				mpc_pkg::REG_STEP:      step_q      <= cfg_data[mpc_pkg::STEP_W-1:0];
				mpc_pkg::REG_MAX_ITER:  max_iter_q  <= cfg_data[mpc_pkg::ITER_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// sequencer and result strobe
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_MAPR;
				end
				ST_MAPR: state_q <= ST_MAPI;
				ST_MAPI: state_q <= ST_CIM;
				ST_CIM:  state_q <= ST_BOX;
				ST_BOX: begin
					if (in_box || (max_iter_q == '0)) begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
					end else begin
						state_q <= ST_SQX;
					end
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: state_q <= ST_XY;
				ST_XY: begin
					// last test without escape: no update needed
					if (escaped || (iter_q == max_iter_q)) begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD:  state_q <= ST_SQX;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					row_q <= pixel_row;
					col_q <= pixel_col;
				end
			end
			ST_MAPI: c_re_q <= c_re_nxt;
			ST_CIM:  c_im_q <= c_im_nxt;
			ST_BOX: begin
				x_q    <= c_re_q;
				y_q    <= c_im_q;
				iter_q <= mpc_pkg::ITER_W'(1);
				if (in_box || (max_iter_q == '0)) begin
					escape_count <= '0;
					inside_set   <= 1'b1;
				end
			end
			ST_SQY: xx_q <= mul_q;
			ST_XY: begin
				diff_q <= xx_q - mul_q;
				if (escaped) begin
					escape_count <= iter_q;
					inside_set   <= 1'b0;
				end else if (iter_q == max_iter_q) begin
					escape_count <= '0;
					inside_set   <= 1'b1;
				end
			end
			ST_UPD: begin
				x_q    <= x_nxt;
				y_q    <= y_nxt;
				iter_q <= iter_q + mpc_pkg::ITER_W'(1);
			end
			default: ;
		endcase
	end

endmodule : mandelbrot_pixel_classifier_core
`default_nettype wire

[hdl/mpc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_checker - port-level checks for the Mandelbrot pixel classifier
// Watches the command, result and configuration ports over time.
// ----------------------------------------------------------------------------
module mpc_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            start,
	input wire                            busy,
	input wire                            done,
	input wire [mpc_pkg::ITER_W-1:0]      escape_count,
	input wire                            inside_set,
	input wire                            cfg_ready
);

	// an accepted start beat makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after start beat");

	// a result only ends a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("done strobe outside a busy period");

	// the strobe lasts exactly one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe held longer than one cycle");

	// inside flag agrees with the count
	a_inside_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (inside_set == (escape_count == '0)))
		else $error("inside_set disagrees with escape_count");

	// configuration is always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel not ready");

endmodule : mpc_checker

bind mandelbrot_pixel_classifier_core mpc_checker u_mpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.escape_count (escape_count),
	.inside_set   (inside_set),
	.cfg_ready    (cfg_ready)
);
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - self-checking bench for mandelbrot_pixel_classifier_core
// A directed table, then randomized views. Each accepted pixel gets an expected
// escape count, hand-typed or predicted in Q4.28; every done beat is checked in order against it.
// ---------------------------------------------------------------------------
module tb_top;
	import mpc_pkg::*;

	localparam int     CLK_HALF     = 2;           // 4 ns period
	localparam longint CYCLE_LIMIT  = 8_000_000;   // outlasts the slowest legal run
	localparam int     TAIL_CYCLES  = 1100;        // outlasts the slowest pixel
	localparam int     PRINT_CAP    = 40;          // keep a broken DUT's log short
	localparam int     PHASES       = 9;

	// Q4.28 / Q8.56 limits used by the escape-time predictor
	localparam longint Q28_MAX      = 64'sd2147483647;
	localparam longint Q28_MIN      = -64'sd2147483648;
	localparam longint RE_LO        = -64'sd134217728;   // -0.5
	localparam longint RE_HI        = 64'sd67108864;     //  0.25
	localparam longint IM_LO        = -64'sd134217728;   // -0.5
	localparam longint IM_HI        = 64'sd134217728;    //  0.5
	localparam longint RADIUS_SQ    = 64'sd288230376151711744; // 4.0 in Q8.56

	// one result beat
	typedef struct packed {
		logic [ITER_W-1:0] count;
		logic              in_set;
	} pixel_result_t;

	// one row of the directed table: either a pixel or a register write
	typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		reg_idx_t          idx;
		logic [Q_W-1:0]    data;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              typed;   // count below is hand-computed, not predicted
		logic [ITER_W-1:0] count;
	} stim_row_t;

	// DUT ports; every input is known from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	logic [ROW_W-1:0]     pixel_row = '0;
	logic [COL_W-1:0]     pixel_col = '0;
	logic                 done;
	logic [ITER_W-1:0]    escape_count;
	logic                 inside_set;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [Q_W-1:0]       cfg_data  = '0;

	// shadow copy of the view registers, reset values of the block
	q_t                   view_re   = -32'sd536870912;  // -2.0
	q_t                   view_im   = 32'sd536870912;   //  2.0
	logic [STEP_W-1:0]    view_step = 29'd2097152;      //  2^-7
	logic [ITER_W-1:0]    view_iter = 8'd200;

	pixel_result_t        pending_results[$];  // escape counts still owed, oldest first
	pixel_result_t        oldest;
	stim_row_t            directed[$];
	int                   mismatches  = 0;
	longint               cycle_count = 0;

	mandelbrot_pixel_classifier_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.pixel_row    (pixel_row),
		.pixel_col    (pixel_col),
		.done         (done),
		.escape_count (escape_count),
		.inside_set   (inside_set),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// Escape-time predictor
	// -----------------------------------------------------------------------

	function automatic longint clamp_q28(input longint v);
		longint r;
		r = v;
		if (v > Q28_MAX)
			r = Q28_MAX;
		else if (v < Q28_MIN)
			r = Q28_MIN;
		return r;
	endfunction

	// Maps the pixel into the current view and runs the escape loop.
	// Products are exact Q8.56; >>> on a signed longint is a floor divide.
	function automatic pixel_result_t classify_pixel(input logic [ROW_W-1:0] row,
	                                                 input logic [COL_W-1:0] col);
		longint        r, c, st, org_re, org_im;
		longint        c_re, c_im, x, y, xx, yy, nx;
		int            i;
		pixel_result_t res;
		r      = row;        // unsigned operands zero-extend
		c      = col;
		st     = view_step;
		org_re = view_re;    // signed operands sign-extend
		org_im = view_im;
		c_re   = clamp_q28(org_re + c * st);
		c_im   = clamp_q28(org_im - r * st);
		res.count = '0;
		// the box test is strict on all four sides; a zero limit skips the loop
		if (!(c_re > RE_LO && c_re < RE_HI && c_im > IM_LO && c_im < IM_HI)) begin
			x = c_re;
			y = c_im;
			for (i = 1; i <= view_iter && res.count == 0; i++) begin
				xx = x * x;
				yy = y * y;
				// two squares of -8 sum to 2^63: compare unsigned
				if ($unsigned(xx) + $unsigned(yy) >= $unsigned(RADIUS_SQ)) begin
					res.count = i[ITER_W-1:0];
				end else begin
					// |x|,|y| < 2 here, so 2*x*y cannot overflow
					nx = clamp_q28(((xx - yy) >>> FRAC_BITS) + c_re);
					y  = clamp_q28(((2 * x * y) >>> FRAC_BITS) + c_im);
					x  = nx;
				end
			end
		end
		res.in_set = (res.count == 0);
		return res;
	endfunction

	// -----------------------------------------------------------------------
	// Drivers. Everything changes by NBA right after a rising edge, and
	// handshakes are judged on the values sampled at that edge. A task that
	// raises a valid leaves it high; the caller lowers it in a later step.
	// -----------------------------------------------------------------------

	task automatic write_reg(input reg_idx_t idx, input logic [Q_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_ORIGIN_RE: view_re   = q_t'(data);
			REG_ORIGIN_IM: view_im   = q_t'(data);
			REG_STEP:      view_step = data[STEP_W-1:0];
			REG_MAX_ITER:  view_iter = data[ITER_W-1:0];
			default: ;
		endcase
	endtask

	// Drop both valids, then wait on clock edges until every owed
	// result beat has arrived. The block is idle after the last done.
	task automatic wait_drained();
		start     <= 1'b0;
		cfg_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// The beat lands on the first edge with start high and busy low. busy
	// drops together with done, so a new beat may share that edge.
	task automatic send_pixel(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
	                          input pixel_result_t want);
		start     <= 1'b1;
		pixel_row <= row;
		pixel_col <= col;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(want);
	endtask

	// Random sender idling: each extra cycle with odds pct out of 100.
	task automatic sender_gap(input int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic add_pixel(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
	                         input logic typed, input logic [ITER_W-1:0] count);
		stim_row_t s;
		s       = '0;
		s.kind  = ROW_PIXEL;
		s.row   = row;
		s.col   = col;
		s.typed = typed;
		s.count = count;
		directed.push_back(s);
	endtask

	task automatic add_reg(input reg_idx_t idx, input logic [Q_W-1:0] data);
		stim_row_t s;
		s      = '0;
		s.kind = ROW_REG;
		s.idx  = idx;
		s.data = data;
		directed.push_back(s);
	endtask

	// -----------------------------------------------------------------------
	// Result checker: done is a one-cycle strobe that cannot be stalled, so
	// every beat sampled at an edge is compared against the oldest owed one.
	// -----------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				if (mismatches < PRINT_CAP)
					$display("%0t: stray beat, expected none, got escape_count=%0d inside_set=%0d",
					         $time, escape_count, inside_set);
				mismatches++;
			end else begin
				oldest = pending_results.pop_front();
				if (escape_count !== oldest.count) begin
					if (mismatches < PRINT_CAP)
						$display("%0t: escape_count expected %0d actual %0d",
						         $time, oldest.count, escape_count);
					mismatches++;
				end
				if (inside_set !== oldest.in_set) begin
					if (mismatches < PRINT_CAP)
						$display("%0t: inside_set expected %0d actual %0d",
						         $time, oldest.in_set, inside_set);
					mismatches++;
				end
			end
		end
	end

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d result beats still owed", $time, pending_results.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus
	// -----------------------------------------------------------------------

	initial begin : stimulus
		pixel_result_t     want;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [Q_W-1:0]    set_re, set_im, set_step, set_iter;
		int                p, k, n_items, idle_pct;

		// Directed table. Reset view: -2+2i at the top-left, 2^-7 per pixel,
		// limit 200. Typed counts are the obvious ones; the rest is predicted.
		add_pixel(9'd0,   9'd0,   1'b1, 8'd1);  // corner -2+2i, escapes at once
		add_pixel(9'd511, 9'd511, 1'b1, 8'd1);  // far corner ~2-2i
		add_pixel(9'd0,   9'd511, 1'b1, 8'd1);
		add_pixel(9'd511, 9'd0,   1'b1, 8'd1);
		add_pixel(9'd256, 9'd256, 1'b1, 8'd0);  // c = 0, inside the box
		add_pixel(9'd256, 9'd128, 1'b1, 8'd0);  // c = -1, period-2 orbit, full run
		add_pixel(9'd256, 9'd0,   1'b1, 8'd1);  // c = -2, |z|^2 exactly 4
		add_pixel(9'd192, 9'd256, 1'b0, 8'd0);  // c = 0.5i, on the box edge
		add_pixel(9'd320, 9'd288, 1'b0, 8'd0);  // c = 0.25-0.5i, box corner
		// zero iteration limit: no test at all, always reported inside
		add_reg(REG_MAX_ITER, 32'd0);
		add_pixel(9'd256, 9'd256, 1'b1, 8'd0);
		add_pixel(9'd0,   9'd0,   1'b1, 8'd0);
		add_reg(REG_MAX_ITER, 32'd255);
		add_pixel(9'd300, 9'd100, 1'b0, 8'd0);
		// zero step: every pixel lands on the origin
		add_reg(REG_STEP, 32'd0);
		add_pixel(9'd511, 9'd511, 1'b1, 8'd1);
		// largest step the register holds: one coordinate saturates in each pixel
		add_reg(REG_STEP, 32'h1FFF_FFFF);
		add_pixel(9'd0,   9'd511, 1'b1, 8'd1);
		add_pixel(9'd511, 9'd0,   1'b1, 8'd1);
		// origin at the Q4.28 extremes
		add_reg(REG_ORIGIN_RE, 32'h7FFF_FFFF);
		add_reg(REG_ORIGIN_IM, 32'h8000_0000);
		add_pixel(9'd0,   9'd0,   1'b1, 8'd1);
		// near -0.75 on the real axis: slow escapes
		add_reg(REG_ORIGIN_RE, 32'hF400_0000);
		add_reg(REG_ORIGIN_IM, 32'h0010_0000);
		add_reg(REG_STEP,      32'h0000_0800);
		add_pixel(9'd0,   9'd0,   1'b0, 8'd0);
		add_pixel(9'd100, 9'd400, 1'b0, 8'd0);
		add_reg(REG_MAX_ITER, 32'd1);
		add_pixel(9'd511, 9'd511, 1'b0, 8'd0);

		// single reset pulse, released on a rising edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[k]) begin
			if (directed[k].kind == ROW_REG) begin
				wait_drained();
				write_reg(directed[k].idx, directed[k].data);
			end else begin
				cfg_valid <= 1'b0;
				if (directed[k].typed) begin
					want.count  = directed[k].count;
					want.in_set = (directed[k].count == 0);
				end else begin
					want = classify_pixel(directed[k].row, directed[k].col);
				end
				send_pixel(directed[k].row, directed[k].col, want);
			end
		end

		// Random views, one setting per phase. Sender idling: 21% for the
		// first three, 80% for the next three, none for the last three.
		// Most limits are small to keep never-escaping pixels cheap.
		for (p = 0; p < PHASES; p++) begin
			idle_pct = (p < 3) ? 21 : (p < 6) ? 80 : 0;
			n_items  = (p == PHASES - 1) ? 60 : 155;
			case (p % 3)
				0: begin
					// classic full view around the set
					set_re   = -32'sd536870912 - $urandom_range(134217728);
					set_im   = 32'd268435456 + $urandom_range(268435456);
					set_step = 32'd1048576 + $urandom_range(2097152);
					set_iter = $urandom_range(32, 1);
				end
				1: begin
					// anything the registers hold, saturation included
					set_re   = $urandom;
					set_im   = $urandom;
					set_step = $urandom;
					set_iter = $urandom;
				end
				default: begin
					// zoomed in near -0.75 + small imaginary part
					set_re   = -32'sd201326592 + $urandom_range(2097152) - 32'd1048576;
					set_im   = $urandom_range(33554432, 4194304);
					set_step = $urandom_range(16384, 1);
					set_iter = $urandom_range(48, 1);
				end
			endcase
			if (p == 0)
				set_iter = 32'd1;
			if (p == 2)
				set_step = 32'd1;
			if (p == 7)
				set_step = 32'd268435456;   // 1.0
			if (p == PHASES - 1)
				set_iter = 32'd255;

			wait_drained();
			write_reg(REG_ORIGIN_RE, set_re);
			write_reg(REG_ORIGIN_IM, set_im);
			write_reg(REG_STEP,      set_step);
			write_reg(REG_MAX_ITER,  set_iter);
			cfg_valid <= 1'b0;

			for (k = 0; k < n_items; k++) begin
				// mid-phase, hold off until the pipe is empty
				if (k == n_items / 2)
					wait_drained();
				sender_gap(idle_pct);
				row = $urandom_range(511);
				col = $urandom_range(511);
				send_pixel(row, col, classify_pixel(row, col));
			end
		end

		// drain, then give a late or extra beat time to show up
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
